@@ sv/fm_operator_matrix_synth_assert.svh @@
// ----------------------------------------------------------------------------
// FM operator matrix synthesizer: assertion macros
// Shared concurrent assertion forms for the modules of this block.
// ----------------------------------------------------------------------------
`ifndef FM_OPERATOR_MATRIX_SYNTH_ASSERT_SVH
`define FM_OPERATOR_MATRIX_SYNTH_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FMOS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fmos assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define FMOS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fmos assertion failed");

`endif

@@ sv/fmos_pkg.sv @@
// ----------------------------------------------------------------------------
// FM operator matrix synthesizer: package
// Sizes, constants, codes and the structs shared by controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fmos_pkg;

    // Block sizes.
    localparam int NUM_OPS         = 4;
    localparam int FIELD_OPS       = 4;
    localparam int PHASE_BITS      = 24;
    localparam int SINE_TABLE_BITS = 10;

    localparam int OP_W      = $clog2(NUM_OPS);
    localparam int CNT_W     = $clog2(NUM_OPS + 1);
    localparam int VAL_W     = 24;
    localparam int MSUM_W    = VAL_W + $clog2(NUM_OPS);
    localparam int MIX_W     = MSUM_W;
    localparam int MUL_A_W   = MSUM_W;
    localparam int MUL_B_W   = 31;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int SIN_QB    = SINE_TABLE_BITS - 2;
    localparam int DIVX_W    = MIX_W - 2;
    localparam int DIV_STEPS = 4;
    localparam int DIV_CYCLES = (DIVX_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DIV_PAD_W = DIV_CYCLES * DIV_STEPS;
    localparam int DIV_CNT_W = $clog2(DIV_CYCLES);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Arithmetic constants.
    localparam logic [16:0] SIN_A = 17'd102873;
    localparam logic [16:0] SIN_B = 17'd41905;
    localparam logic [16:0] SIN_C = 17'd4569;
    localparam logic [29:0] INV_TWO_PI = 30'd683565276;
    localparam logic [15:0] VOLUME_RESET = 16'd16384;
    localparam logic [16:0] WAVE_ONE = 17'd32768;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_STEP,
        CFG_MOD_MATRIX,
        CFG_WAVE_SELECT,
        CFG_START_PHASES,
        CFG_VOLUME
    } t_cfg_index;

    // Wave shapes.
    typedef enum logic [1:0] {
        WAVE_SINE,
        WAVE_TRI,
        WAVE_SAW,
        WAVE_SQUARE
    } t_wave;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MSUM,
        ST_T,
        ST_T2,
        ST_V,
        ST_AMP,
        ST_LAST,
        ST_MOD,
        ST_PHASE,
        ST_MIX,
        ST_ABS,
        ST_DIV,
        ST_OUT
    } t_state;

    // Datapath step codes.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_MSUM,
        CMD_T,
        CMD_T2,
        CMD_V,
        CMD_AMP,
        CMD_LAST,
        CMD_MOD,
        CMD_PHASE,
        CMD_MIX,
        CMD_ABS,
        CMD_DIV
    } t_cmd_code;

    typedef struct packed {
        t_cmd_code       code;
        logic [OP_W-1:0] op;
        logic            load;
        logic            push;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_status;

    // Input word.
    typedef struct packed {
        logic        restart;
        logic [15:0] freq_ratio_0;
        logic [15:0] freq_ratio_1;
        logic [15:0] freq_ratio_2;
        logic [15:0] freq_ratio_3;
        logic [15:0] amp_0;
        logic [15:0] amp_1;
        logic [15:0] amp_2;
        logic [15:0] amp_3;
    } t_in_item;

    // Output word.
    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               clipped;
    } t_out_item;

endpackage

`default_nettype wire

@@ sv/fm_operator_matrix_synth.sv @@
// ----------------------------------------------------------------------------
// FM operator matrix synthesizer: top level
// Four-operator FM voice, one mixed sample per input word.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (i_in_valid / o_in_stall / i_in_data) carries the restart
//  flag, frequency ratios and amplitudes of one sample. Output channel
//  (o_out_valid / i_out_stall / o_out_data) carries the saturated sample and
//  the clip flag. A word moves when valid is high and stall is low.
//  Configuration is to be written through i_cfg_we / i_cfg_index / i_cfg_data
//  only while the block is idle; the block itself does not enforce this.
//  Each operator runs eight steps on the one shared multiplier (sine
//  polynomial, amplitude, phase step, modulation, phase update). After the
//  last operator, one mix multiply and a divide by the audible count
//  follow, and the result is pushed into the output register. A new input
//  word is taken only after the controller has returned to idle.
//  The next input word is taken while the result still waits in the output
//  register; only a new result waits for the register to free up.
//  Reset clears the configuration to its defaults, all phases and operator
//  values to zero, and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fm_operator_matrix_synth (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [fmos_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [fmos_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire fmos_pkg::t_in_item              i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output fmos_pkg::t_out_item                  o_out_data
);

    fmos_pkg::t_cmd    cmd;
    fmos_pkg::t_status status;

    // Sequencer.
    fmos_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Arithmetic and state.
    fmos_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

@@ sv/fmos_ctrl.sv @@
// ----------------------------------------------------------------------------
// FM operator matrix synthesizer: controller
// Sequences the datapath through the operators, the mix and the divide.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fm_operator_matrix_synth_assert.svh"

module fmos_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire fmos_pkg::t_status i_status,
    output fmos_pkg::t_cmd        o_cmd
);

    fmos_pkg::t_state r_state, n_state;
    logic [fmos_pkg::OP_W-1:0]      r_op, n_op;
    logic [fmos_pkg::DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;
    logic                           accept;
    logic                           last_op;

    assign o_in_stall = (r_state != fmos_pkg::ST_IDLE);
    assign accept     = i_in_valid && (r_state == fmos_pkg::ST_IDLE);
    assign last_op    = (r_op == fmos_pkg::OP_W'(fmos_pkg::NUM_OPS - 1));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fmos_pkg::ST_IDLE:  if (accept) n_state = fmos_pkg::ST_MSUM;
            fmos_pkg::ST_MSUM:  n_state = fmos_pkg::ST_T;
            fmos_pkg::ST_T:     n_state = fmos_pkg::ST_T2;
            fmos_pkg::ST_T2:    n_state = fmos_pkg::ST_V;
            fmos_pkg::ST_V:     n_state = fmos_pkg::ST_AMP;
            fmos_pkg::ST_AMP:   n_state = fmos_pkg::ST_LAST;
            fmos_pkg::ST_LAST:  n_state = fmos_pkg::ST_MOD;
            fmos_pkg::ST_MOD:   n_state = fmos_pkg::ST_PHASE;
            fmos_pkg::ST_PHASE: n_state = last_op ? fmos_pkg::ST_MIX : fmos_pkg::ST_MSUM;
            fmos_pkg::ST_MIX:   n_state = fmos_pkg::ST_ABS;
            fmos_pkg::ST_ABS:   n_state = fmos_pkg::ST_DIV;
            fmos_pkg::ST_DIV:   if (r_div_cnt == '0) n_state = fmos_pkg::ST_OUT;
            fmos_pkg::ST_OUT:   if (!i_status.out_busy) n_state = fmos_pkg::ST_IDLE;
            default:            n_state = fmos_pkg::ST_IDLE;
        endcase
    end

    // Operator index and divide step counter.
    always_comb begin
        n_op      = r_op;
        n_div_cnt = r_div_cnt;
        if (accept) begin
            n_op = '0;
        end else if (r_state == fmos_pkg::ST_PHASE && !last_op) begin
            n_op = fmos_pkg::OP_W'(r_op + 1'b1);
        end
        if (r_state == fmos_pkg::ST_ABS) begin
            n_div_cnt = fmos_pkg::DIV_CNT_W'(fmos_pkg::DIV_CYCLES - 1);
        end else if (r_state == fmos_pkg::ST_DIV) begin
            n_div_cnt = fmos_pkg::DIV_CNT_W'(r_div_cnt - 1'b1);
        end
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd.op   = r_op;
        o_cmd.load = accept;
        o_cmd.push = 1'b0;
        unique case (r_state)
            fmos_pkg::ST_IDLE:  o_cmd.code = fmos_pkg::CMD_NONE;
            fmos_pkg::ST_MSUM:  o_cmd.code = fmos_pkg::CMD_MSUM;
            fmos_pkg::ST_T:     o_cmd.code = fmos_pkg::CMD_T;
            fmos_pkg::ST_T2:    o_cmd.code = fmos_pkg::CMD_T2;
            fmos_pkg::ST_V:     o_cmd.code = fmos_pkg::CMD_V;
            fmos_pkg::ST_AMP:   o_cmd.code = fmos_pkg::CMD_AMP;
            fmos_pkg::ST_LAST:  o_cmd.code = fmos_pkg::CMD_LAST;
            fmos_pkg::ST_MOD:   o_cmd.code = fmos_pkg::CMD_MOD;
            fmos_pkg::ST_PHASE: o_cmd.code = fmos_pkg::CMD_PHASE;
            fmos_pkg::ST_MIX:   o_cmd.code = fmos_pkg::CMD_MIX;
            fmos_pkg::ST_ABS:   o_cmd.code = fmos_pkg::CMD_ABS;
            fmos_pkg::ST_DIV:   o_cmd.code = fmos_pkg::CMD_DIV;
            fmos_pkg::ST_OUT: begin
                o_cmd.code = fmos_pkg::CMD_NONE;
                o_cmd.push = !i_status.out_busy;
            end
            default:            o_cmd.code = fmos_pkg::CMD_NONE;
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= fmos_pkg::ST_IDLE;
            r_op      <= '0;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_op      <= n_op;
            r_div_cnt <= n_div_cnt;
        end
    end

    `FMOS_ASSERT_NEXT(a_accept_starts_op0, i_clk, i_rst_n, (i_in_valid && !o_in_stall), (r_state == fmos_pkg::ST_MSUM && r_op == '0))
    `FMOS_ASSERT_NEXT(a_next_op_follows, i_clk, i_rst_n, (r_state == fmos_pkg::ST_PHASE && !last_op), (r_state == fmos_pkg::ST_MSUM && r_op == $past(r_op) + 1'b1))

endmodule

`default_nettype wire

@@ sv/fmos_datapath.sv @@
// ----------------------------------------------------------------------------
// FM operator matrix synthesizer: datapath
// Configuration registers, operator state, shared multiplier, divider and
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fm_operator_matrix_synth_assert.svh"

module fmos_datapath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [fmos_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [fmos_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire fmos_pkg::t_in_item              i_in_data,
    input  wire fmos_pkg::t_cmd                  i_cmd,
    output fmos_pkg::t_status                    o_status,
    input  wire logic                            i_out_stall,
    output logic                                 o_out_valid,
    output fmos_pkg::t_out_item                  o_out_data
);

    localparam int PB = fmos_pkg::PHASE_BITS;
    localparam int NO = fmos_pkg::NUM_OPS;
    localparam int FO = fmos_pkg::FIELD_OPS;

    // Configuration registers.
    logic [23:0] r_base_step;
    logic [15:0] r_mod_matrix;
    logic [7:0]  r_wave_sel;
    logic [63:0] r_start;
    logic [15:0] r_volume;

    // Operator state and work registers.
    logic        [PB-1:0]                r_phase [NO];
    logic signed [fmos_pkg::VAL_W-1:0]   r_last  [NO];
    fmos_pkg::t_in_item                  r_in;
    logic signed [fmos_pkg::MSUM_W-1:0]  r_msum;
    logic                                r_aud;
    logic        [16:0]                  r_z;
    logic        [16:0]                  r_z2;
    logic        [PB-1:0]                r_step;
    logic signed [fmos_pkg::MIX_W-1:0]   r_mix;
    logic        [fmos_pkg::CNT_W-1:0]   r_count;
    logic signed [fmos_pkg::PROD_W-1:0]  r_prod;
    logic                                r_sign;
    logic        [fmos_pkg::DIV_PAD_W-1:0] r_dq;
    logic        [fmos_pkg::CNT_W-1:0]   r_rem;
    fmos_pkg::t_out_item                 r_out;
    logic                                r_out_valid;

    // Combinational values.
    logic [15:0]                        f_ratio [FO];
    logic [15:0]                        f_amp   [FO];
    logic [15:0]                        cur_ratio;
    logic [15:0]                        cur_amp;
    logic [1:0]                         cur_sel;
    logic [PB-1:0]                      cur_phase;
    logic signed [fmos_pkg::MSUM_W-1:0] msum;
    logic                               aud;
    logic [SINE_BITS_M1:0]              k;
    logic [1:0]                         quad;
    logic [fmos_pkg::SIN_QB:0]          zn;
    logic [16:0]                        z_cur;
    logic [15:0]                        h;
    logic [16:0]                        vcap;
    logic signed [16:0]                 wave;
    logic signed [fmos_pkg::VAL_W-1:0]  op_val;
    logic signed [fmos_pkg::MUL_A_W-1:0] mul_a;
    logic signed [fmos_pkg::MUL_B_W-1:0] mul_b;
    logic signed [fmos_pkg::PROD_W-1:0] n_prod;
    logic [fmos_pkg::PROD_W-1:0]        mag;
    logic [fmos_pkg::DIV_PAD_W-1:0]     n_dq;
    logic [fmos_pkg::CNT_W:0]           n_rem;
    fmos_pkg::t_out_item                result;

    localparam int SINE_BITS_M1 = fmos_pkg::SINE_TABLE_BITS - 1;

    assign f_ratio[0] = r_in.freq_ratio_0;
    assign f_ratio[1] = r_in.freq_ratio_1;
    assign f_ratio[2] = r_in.freq_ratio_2;
    assign f_ratio[3] = r_in.freq_ratio_3;
    assign f_amp[0]   = r_in.amp_0;
    assign f_amp[1]   = r_in.amp_1;
    assign f_amp[2]   = r_in.amp_2;
    assign f_amp[3]   = r_in.amp_3;

    // Per-operator inputs; operators without fields get zero and sine.
    always_comb begin
        cur_ratio = '0;
        cur_amp   = '0;
        cur_sel   = fmos_pkg::WAVE_SINE;
        for (int f = 0; f < FO; f++) begin
            if (int'(i_cmd.op) == f) begin
                cur_ratio = f_ratio[f];
                cur_amp   = f_amp[f];
                cur_sel   = r_wave_sel[2*f +: 2];
            end
        end
    end

    assign cur_phase = r_phase[i_cmd.op];

    // Modulation sum and audibility of the current operator.
    always_comb begin
        msum = '0;
        aud  = 1'b1;
        for (int p = 0; p < NO; p++) begin
            for (int f = 0; f < FO; f++) begin
                if (int'(i_cmd.op) == f && p < FO) begin
                    if (r_mod_matrix[(p % FO) * FO + f]) begin
                        msum = msum + fmos_pkg::MSUM_W'(r_last[p]);
                    end
                    if (r_mod_matrix[f * FO + (p % FO)]) begin
                        aud = 1'b0;
                    end
                end
            end
        end
    end

    // Quarter-wave argument of the sine polynomial.
    assign k     = cur_phase[PB-1 -: fmos_pkg::SINE_TABLE_BITS];
    assign quad  = k[SINE_BITS_M1 -: 2];
    assign zn    = quad[0] ? ((fmos_pkg::SIN_QB + 1)'(1 << fmos_pkg::SIN_QB)
                              - {1'b0, k[fmos_pkg::SIN_QB-1:0]})
                           : {1'b0, k[fmos_pkg::SIN_QB-1:0]};
    assign z_cur = 17'(zn) << (16 - fmos_pkg::SIN_QB);
    assign h     = cur_phase[PB-1 -: 16];
    assign vcap  = (r_prod[33:17] > fmos_pkg::WAVE_ONE) ? fmos_pkg::WAVE_ONE : r_prod[33:17];

    // Wave value of the current operator.
    always_comb begin
        case (cur_sel)
            fmos_pkg::WAVE_SINE:
                wave = quad[1] ? (17'sd0 - signed'(vcap)) : signed'(vcap);
            fmos_pkg::WAVE_TRI: begin
                case (h[15:14])
                    2'd0:    wave = signed'({2'b00, h[13:0], 1'b0});
                    2'd1:    wave = signed'(fmos_pkg::WAVE_ONE) - signed'({2'b00, h[13:0], 1'b0});
                    2'd2:    wave = 17'sd0 - signed'({2'b00, h[13:0], 1'b0});
                    default: wave = signed'({2'b00, h[13:0], 1'b0}) - signed'(fmos_pkg::WAVE_ONE);
                endcase
            end
            fmos_pkg::WAVE_SAW:
                wave = signed'(fmos_pkg::WAVE_ONE) - signed'({1'b0, h});
            default:
                wave = (cur_phase <= PB'(1 << (PB - 1))) ? signed'(fmos_pkg::WAVE_ONE)
                                                         : (17'sd0 - signed'(fmos_pkg::WAVE_ONE));
        endcase
    end

    assign op_val = signed'(r_prod[8 +: fmos_pkg::VAL_W]);

    // Shared multiplier operand select.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.code)
            fmos_pkg::CMD_MSUM: begin
                mul_a = fmos_pkg::MUL_A_W'(z_cur);
                mul_b = fmos_pkg::MUL_B_W'(z_cur);
            end
            fmos_pkg::CMD_T: begin
                mul_a = fmos_pkg::MUL_A_W'(r_prod[32:16]);
                mul_b = fmos_pkg::MUL_B_W'(fmos_pkg::SIN_C);
            end
            fmos_pkg::CMD_T2: begin
                mul_a = fmos_pkg::MUL_A_W'(r_z2);
                mul_b = fmos_pkg::MUL_B_W'(17'(fmos_pkg::SIN_B - r_prod[32:16]));
            end
            fmos_pkg::CMD_V: begin
                mul_a = fmos_pkg::MUL_A_W'(r_z);
                mul_b = fmos_pkg::MUL_B_W'(17'(fmos_pkg::SIN_A - r_prod[32:16]));
            end
            fmos_pkg::CMD_AMP: begin
                mul_a = fmos_pkg::MUL_A_W'(cur_amp);
                mul_b = fmos_pkg::MUL_B_W'(wave);
            end
            fmos_pkg::CMD_LAST: begin
                mul_a = fmos_pkg::MUL_A_W'(r_base_step);
                mul_b = fmos_pkg::MUL_B_W'(cur_ratio);
            end
            fmos_pkg::CMD_MOD: begin
                mul_a = fmos_pkg::MUL_A_W'(r_msum);
                mul_b = fmos_pkg::MUL_B_W'(fmos_pkg::INV_TWO_PI);
            end
            fmos_pkg::CMD_MIX: begin
                mul_a = fmos_pkg::MUL_A_W'(r_mix);
                mul_b = fmos_pkg::MUL_B_W'(r_volume);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign n_prod = mul_a * mul_b;
    assign mag    = r_prod[fmos_pkg::PROD_W-1] ? fmos_pkg::PROD_W'(-r_prod)
                                               : fmos_pkg::PROD_W'(r_prod);

    // Restoring divide by the audible count, several quotient bits a cycle.
    always_comb begin
        n_dq  = r_dq;
        n_rem = {1'b0, r_rem};
        for (int j = 0; j < fmos_pkg::DIV_STEPS; j++) begin
            n_rem = {n_rem[fmos_pkg::CNT_W-1:0], n_dq[fmos_pkg::DIV_PAD_W-1]};
            n_dq  = {n_dq[fmos_pkg::DIV_PAD_W-2:0], 1'b0};
            if (n_rem >= {1'b0, r_count}) begin
                n_rem   = n_rem - {1'b0, r_count};
                n_dq[0] = 1'b1;
            end
        end
    end

    // Sign, saturation and the no-audible-operator case.
    always_comb begin
        result.sample_out = '0;
        result.clipped    = 1'b0;
        if (r_count != '0) begin
            if (!r_sign) begin
                if (r_dq > fmos_pkg::DIV_PAD_W'(32767)) begin
                    result.sample_out = 16'sh7fff;
                    result.clipped    = 1'b1;
                end else begin
                    result.sample_out = signed'(r_dq[15:0]);
                end
            end else begin
                if (r_dq > fmos_pkg::DIV_PAD_W'(32768)) begin
                    result.sample_out = 16'sh8000;
                    result.clipped    = 1'b1;
                end else begin
                    result.sample_out = signed'(16'd0 - r_dq[15:0]);
                end
            end
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_step  <= '0;
            r_mod_matrix <= '0;
            r_wave_sel   <= '0;
            r_start      <= '0;
            r_volume     <= fmos_pkg::VOLUME_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fmos_pkg::CFG_BASE_STEP:    r_base_step  <= i_cfg_data[23:0];
                fmos_pkg::CFG_MOD_MATRIX:   r_mod_matrix <= i_cfg_data[15:0];
                fmos_pkg::CFG_WAVE_SELECT:  r_wave_sel   <= i_cfg_data[7:0];
                fmos_pkg::CFG_START_PHASES: r_start      <= i_cfg_data;
                fmos_pkg::CFG_VOLUME:       r_volume     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Operator phases and last values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int o = 0; o < NO; o++) begin
                r_phase[o] <= '0;
                r_last[o]  <= '0;
            end
        end else if (i_cmd.load && i_in_data.restart) begin
            for (int o = 0; o < NO; o++) begin
                if (o < FO) begin
                    r_phase[o] <= PB'(r_start[16*(o % FO) +: 16]) << (PB - 16);
                end else begin
                    r_phase[o] <= '0;
                end
                r_last[o] <= '0;
            end
        end else if (i_cmd.code == fmos_pkg::CMD_LAST) begin
            r_last[i_cmd.op] <= op_val;
        end else if (i_cmd.code == fmos_pkg::CMD_PHASE) begin
            r_phase[i_cmd.op] <= PB'(cur_phase + r_step + r_prod[50 -: PB]);
        end
    end

    // Work registers.
    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (i_cmd.load) begin
            r_in    <= i_in_data;
            r_mix   <= '0;
            r_count <= '0;
        end
        case (i_cmd.code)
            fmos_pkg::CMD_MSUM: begin
                r_msum <= msum;
                r_aud  <= aud;
                r_z    <= z_cur;
            end
            fmos_pkg::CMD_T: r_z2 <= r_prod[32:16];
            fmos_pkg::CMD_LAST: begin
                if (r_aud) begin
                    r_mix   <= r_mix + fmos_pkg::MIX_W'(op_val);
                    r_count <= fmos_pkg::CNT_W'(r_count + 1'b1);
                end
            end
            fmos_pkg::CMD_MOD: r_step <= r_prod[31 -: PB];
            fmos_pkg::CMD_ABS: begin
                r_sign <= r_prod[fmos_pkg::PROD_W-1];
                r_dq   <= fmos_pkg::DIV_PAD_W'(mag[18 +: fmos_pkg::DIVX_W]);
                r_rem  <= '0;
            end
            fmos_pkg::CMD_DIV: begin
                r_dq  <= n_dq;
                r_rem <= n_rem[fmos_pkg::CNT_W-1:0];
            end
            default: ;
        endcase
        if (i_cmd.push) begin
            r_out <= result;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.out_busy = r_out_valid && i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

    `FMOS_ASSERT_NEXT(a_restart_clears, i_clk, i_rst_n, (i_cmd.load && i_in_data.restart), (r_last[0] == '0 && r_mix == '0 && r_count == '0))
    `FMOS_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, (r_count <= fmos_pkg::CNT_W'(NO)))

endmodule

`default_nettype wire
